// ===== rtl/rse_pkg.sv =====
// Package of the resolver signal emulator: default sizes, register indexes,
// configuration and command types, controller states and the quarter-wave sine function.
// Depends on nothing; every other file of the block uses it.
package rse_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int SINE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_ADDR_BITS = 5;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_EXC_STEP,
		REG_ROTOR_STEP,
		REG_SIN_GAIN,
		REG_COS_GAIN,
		REG_SIN_SHIFT,
		REG_COS_SHIFT,
		REG_SIN_OFFSET,
		REG_COS_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] exc_step;
		logic [31:0] rotor_step;
		logic [14:0] sin_gain;
		logic [14:0] cos_gain;
		logic [31:0] sin_shift;
		logic [31:0] cos_shift;
		logic signed [15:0] sin_offset;
		logic signed [15:0] cos_offset;
	} cfg_t;

	typedef enum logic [2:0] {
		LK_NONE,
		LK_EXC,
		LK_SC,
		LK_CC,
		LK_SA,
		LK_CA
	} lk_sel_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SIN_PROD,
		MUL_COS_PROD,
		MUL_SIN_GAIN,
		MUL_COS_GAIN
	} mul_sel_t;

	typedef struct packed {
		logic load;
		lk_sel_t lk_sel;
		mul_sel_t mul_sel;
		logic fin_sin;
		logic fin_cos;
		logic advance;
		logic out_load;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LK_EXC,
		ST_LK_SC,
		ST_LK_SA,
		ST_LK_CC,
		ST_LK_CA,
		ST_FIN_S,
		ST_MUL_CG,
		ST_FIN_C,
		ST_DONE
	} state_t;

	// First-quadrant sine in Q30 by an odd Taylor polynomial, scaled to full sample range.
	function automatic logic [63:0] quarter_sine(input logic [63:0] q, input int addr_bits,
			input int sample_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] smax;
		smax = (64'd1 << (sample_bits - 1)) - 64'd1;
		x = (HALF_PI_Q30 * q) >> (addr_bits - 2);
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		v = (s * smax + (Q30_ONE >> 1)) >> 30;
		if (v > smax) begin
			v = smax;
		end
		return v;
	endfunction

endpackage

// ===== rtl/rse_regs.sv =====
// Configuration register file of the resolver signal emulator behind an APB-style port.
// Depends on rse_pkg for the register indexes and the configuration struct.
module rse_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rse_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output rse_pkg::cfg_t                   cfg
);

	rse_pkg::cfg_t cfg_q;
	rse_pkg::reg_idx_t idx;

	assign idx = rse_pkg::reg_idx_t'(paddr[rse_pkg::CFG_ADDR_BITS-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exc_step <= 32'd10737418;
			cfg_q.rotor_step <= 32'd13675187;
			cfg_q.sin_gain <= 15'd26214;
			cfg_q.cos_gain <= 15'd26214;
			cfg_q.sin_shift <= 32'd0;
			cfg_q.cos_shift <= 32'd0;
			cfg_q.sin_offset <= 16'sd0;
			cfg_q.cos_offset <= 16'sd0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				rse_pkg::REG_EXC_STEP: cfg_q.exc_step <= pwdata;
				rse_pkg::REG_ROTOR_STEP: cfg_q.rotor_step <= pwdata;
				rse_pkg::REG_SIN_GAIN: cfg_q.sin_gain <= pwdata[14:0];
				rse_pkg::REG_COS_GAIN: cfg_q.cos_gain <= pwdata[14:0];
				rse_pkg::REG_SIN_SHIFT: cfg_q.sin_shift <= pwdata;
				rse_pkg::REG_COS_SHIFT: cfg_q.cos_shift <= pwdata;
				rse_pkg::REG_SIN_OFFSET: cfg_q.sin_offset <= signed'(pwdata[15:0]);
				rse_pkg::REG_COS_OFFSET: cfg_q.cos_offset <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rse_pkg::REG_EXC_STEP: prdata = cfg_q.exc_step;
			rse_pkg::REG_ROTOR_STEP: prdata = cfg_q.rotor_step;
			rse_pkg::REG_SIN_GAIN: prdata = {17'd0, cfg_q.sin_gain};
			rse_pkg::REG_COS_GAIN: prdata = {17'd0, cfg_q.cos_gain};
			rse_pkg::REG_SIN_SHIFT: prdata = cfg_q.sin_shift;
			rse_pkg::REG_COS_SHIFT: prdata = cfg_q.cos_shift;
			rse_pkg::REG_SIN_OFFSET: prdata = 32'(cfg_q.sin_offset);
			rse_pkg::REG_COS_OFFSET: prdata = 32'(cfg_q.cos_offset);
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/rse_ctrl.sv =====
// Controller of the resolver signal emulator: sequences the table lookups, products and
// output load of one request, and owns the input and output handshakes. Depends on rse_pkg.
module rse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rse_pkg::cmd_t  cmd
);

	rse_pkg::state_t state_q;
	rse_pkg::state_t state_d;
	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == rse_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rse_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.lk_sel = rse_pkg::LK_NONE;
		cmd.mul_sel = rse_pkg::MUL_NONE;
		cmd.fin_sin = 1'b0;
		cmd.fin_cos = 1'b0;
		cmd.advance = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			rse_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rse_pkg::ST_LK_EXC;
				end
			end
			rse_pkg::ST_LK_EXC: begin
				cmd.lk_sel = rse_pkg::LK_EXC;
				state_d = rse_pkg::ST_LK_SC;
			end
			rse_pkg::ST_LK_SC: begin
				cmd.lk_sel = rse_pkg::LK_SC;
				state_d = rse_pkg::ST_LK_SA;
			end
			rse_pkg::ST_LK_SA: begin
				cmd.lk_sel = rse_pkg::LK_SA;
				state_d = rse_pkg::ST_LK_CC;
			end
			rse_pkg::ST_LK_CC: begin
				cmd.lk_sel = rse_pkg::LK_CC;
				cmd.mul_sel = rse_pkg::MUL_SIN_PROD;
				state_d = rse_pkg::ST_LK_CA;
			end
			rse_pkg::ST_LK_CA: begin
				cmd.lk_sel = rse_pkg::LK_CA;
				cmd.mul_sel = rse_pkg::MUL_SIN_GAIN;
				state_d = rse_pkg::ST_FIN_S;
			end
			rse_pkg::ST_FIN_S: begin
				cmd.fin_sin = 1'b1;
				cmd.mul_sel = rse_pkg::MUL_COS_PROD;
				state_d = rse_pkg::ST_MUL_CG;
			end
			rse_pkg::ST_MUL_CG: begin
				cmd.mul_sel = rse_pkg::MUL_COS_GAIN;
				state_d = rse_pkg::ST_FIN_C;
			end
			rse_pkg::ST_FIN_C: begin
				cmd.fin_cos = 1'b1;
				cmd.advance = 1'b1;
				state_d = rse_pkg::ST_DONE;
			end
			rse_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = rse_pkg::ST_IDLE;
				end
			end
			default: state_d = rse_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/rse_dp.sv =====
// Datapath of the resolver signal emulator: phase accumulators, one sine table port,
// one shared multiplier, rounding, offset and saturation, and the output register.
// Depends on rse_pkg for the command and configuration types and the sine function.
module rse_dp #(
	parameter int PHASE_BITS = rse_pkg::PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = rse_pkg::SINE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS = rse_pkg::SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rse_pkg::cmd_t       cmd,
	input  rse_pkg::cfg_t       cfg,
	input  logic                restart,
	output logic signed [15:0]  excitation,
	output logic signed [15:0]  sin_secondary,
	output logic signed [15:0]  cos_secondary,
	output logic [15:0]         rotor_angle
);

	localparam int PB = PHASE_BITS;
	localparam int AB = SINE_ADDR_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int QSIZE = 1 << (AB - 2);
	localparam int GB = (SB > 15) ? SB : 15;
	localparam int AW = 2 * SB;
	localparam int PRW = AW + GB;
	localparam int SH = 14 + SB;
	localparam int VW = ((SB > 16) ? SB : 16) + 2;
	localparam logic [PRW:0] HALF = (PRW + 1)'(1) << (SH - 1);
	localparam logic signed [VW-1:0] SMAX = VW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] SMIN = -SMAX - VW'(1);

	function automatic logic [PB-1:0] to_ph(input logic [31:0] v);
		logic [PB+31:0] x;
		x = {v, {PB{1'b0}}};
		return x[PB+31:32];
	endfunction

	logic [SB-2:0] qtab [QSIZE+1];

	for (genvar k = 0; k <= QSIZE; k++) begin : g_qtab
		assign qtab[k] = (SB - 1)'(rse_pkg::quarter_sine(64'(k), AB, SB));
	end

	logic [PB-1:0] carrier_q;
	logic [PB-1:0] angle_q;
	logic signed [SB-1:0] exc_q;
	logic signed [SB-1:0] sc_q;
	logic signed [SB-1:0] cc_q;
	logic signed [SB-1:0] sa_q;
	logic signed [SB-1:0] ca_q;
	logic [15:0] ang_q;
	logic [PRW-1:0] prod_q;
	logic neg_q;
	logic [15:0] sin_res_q;
	logic [15:0] cos_res_q;
	logic signed [15:0] exc_out_q;
	logic signed [15:0] sin_out_q;
	logic signed [15:0] cos_out_q;
	logic [15:0] ang_out_q;

	logic [PB-1:0] lk_ph;
	logic [AB-1:0] lk_idx;
	logic [AB-2:0] lk_addr;
	logic [SB-2:0] lk_mag;
	logic signed [SB-1:0] lk_val;

	always_comb begin
		case (cmd.lk_sel)
			rse_pkg::LK_SC: lk_ph = carrier_q + to_ph(cfg.sin_shift);
			rse_pkg::LK_CC: lk_ph = carrier_q + to_ph(cfg.cos_shift);
			rse_pkg::LK_SA: lk_ph = angle_q;
			rse_pkg::LK_CA: lk_ph = angle_q;
			default: lk_ph = carrier_q;
		endcase
		lk_idx = lk_ph[PB-1 -: AB];
		if (cmd.lk_sel == rse_pkg::LK_CA) begin
			lk_idx = lk_idx + AB'(QSIZE);
		end
		lk_addr = lk_idx[AB-2] ? ((AB - 1)'(QSIZE) - {1'b0, lk_idx[AB-3:0]})
			: {1'b0, lk_idx[AB-3:0]};
		lk_mag = qtab[lk_addr];
		lk_val = lk_idx[AB-1] ? -signed'({1'b0, lk_mag}) : signed'({1'b0, lk_mag});
	end

	logic [SB-1:0] sc_mag;
	logic [SB-1:0] cc_mag;
	logic [SB-1:0] sa_mag;
	logic [SB-1:0] ca_mag;
	logic [AW-1:0] mul_a;
	logic [GB-1:0] mul_b;
	logic [PRW-1:0] prod;

	assign sc_mag = sc_q[SB-1] ? SB'(-sc_q) : SB'(sc_q);
	assign cc_mag = cc_q[SB-1] ? SB'(-cc_q) : SB'(cc_q);
	assign sa_mag = sa_q[SB-1] ? SB'(-sa_q) : SB'(sa_q);
	assign ca_mag = ca_q[SB-1] ? SB'(-ca_q) : SB'(ca_q);

	always_comb begin
		case (cmd.mul_sel)
			rse_pkg::MUL_SIN_PROD: begin
				mul_a = AW'(sc_mag);
				mul_b = GB'(sa_mag);
			end
			rse_pkg::MUL_COS_PROD: begin
				mul_a = AW'(cc_mag);
				mul_b = GB'(ca_mag);
			end
			rse_pkg::MUL_SIN_GAIN: begin
				mul_a = prod_q[AW-1:0];
				mul_b = GB'(cfg.sin_gain);
			end
			rse_pkg::MUL_COS_GAIN: begin
				mul_a = prod_q[AW-1:0];
				mul_b = GB'(cfg.cos_gain);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	logic [PRW:0] rnd;
	logic [SB:0] rmag;
	logic signed [VW-1:0] rval;
	logic signed [VW-1:0] sum;
	logic signed [VW-1:0] sat;

	always_comb begin
		rnd = {1'b0, prod_q} + HALF;
		rmag = rnd[SH +: SB + 1];
		rval = signed'(VW'(rmag));
		if (neg_q) begin
			rval = -rval;
		end
		sum = rval + (cmd.fin_sin ? VW'(cfg.sin_offset) : VW'(cfg.cos_offset));
		if (sum > SMAX) begin
			sat = SMAX;
		end else if (sum < SMIN) begin
			sat = SMIN;
		end else begin
			sat = sum;
		end
	end

	logic signed [31:0] exc_ext;
	assign exc_ext = 32'(exc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			angle_q <= '0;
		end else if (cmd.load && restart) begin
			carrier_q <= '0;
			angle_q <= '0;
		end else if (cmd.advance) begin
			carrier_q <= carrier_q + to_ph(cfg.exc_step);
			angle_q <= angle_q + to_ph(cfg.rotor_step);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.lk_sel)
			rse_pkg::LK_EXC: begin
				exc_q <= lk_val;
				ang_q <= angle_q[PB-1 -: 16];
			end
			rse_pkg::LK_SC: sc_q <= lk_val;
			rse_pkg::LK_CC: cc_q <= lk_val;
			rse_pkg::LK_SA: sa_q <= lk_val;
			rse_pkg::LK_CA: ca_q <= lk_val;
			default: ;
		endcase
		if (cmd.mul_sel != rse_pkg::MUL_NONE) begin
			prod_q <= prod;
		end
		if (cmd.mul_sel == rse_pkg::MUL_SIN_PROD) begin
			neg_q <= sc_q[SB-1] ^ sa_q[SB-1];
		end else if (cmd.mul_sel == rse_pkg::MUL_COS_PROD) begin
			neg_q <= cc_q[SB-1] ^ ca_q[SB-1];
		end
		if (cmd.fin_sin) begin
			sin_res_q <= sat[15:0];
		end
		if (cmd.fin_cos) begin
			cos_res_q <= sat[15:0];
		end
		if (cmd.out_load) begin
			exc_out_q <= exc_ext[15:0];
			sin_out_q <= sin_res_q;
			cos_out_q <= cos_res_q;
			ang_out_q <= ang_q;
		end
	end

	assign excitation = exc_out_q;
	assign sin_secondary = sin_out_q;
	assign cos_secondary = cos_out_q;
	assign rotor_angle = ang_out_q;

endmodule

// ===== rtl/resolver_signal_emulator.sv =====
// Top level of the resolver signal emulator: register file, controller and datapath.
// Depends on rse_pkg, rse_regs, rse_ctrl and rse_dp.
//
// Each input request is one sample tick; its only field, restart, clears the excitation
// and rotor phase accumulators before the tick is computed. Each request gives one result:
// the excitation sine, the sin and cos secondary samples and the top 16 bits of the rotor
// angle taken before the accumulators advance.
// Both channels use valid and ready. The configuration registers sit behind an APB-style
// port at byte address 4*i, are written in the access cycle and are read back as stored.
// For each request the controller steps through five sine lookups on the single table port
// and four products on the single multiplier, then loads the output register. A new request
// is accepted only after the last one has been loaded into the output register. When the
// receiver stalls, the finished result waits in the output register and the next request is
// accepted and computed; its result waits inside until the output frees. Reset clears the
// accumulators, the controller and out_valid and loads the register defaults; no request is
// lost or repeated across a stall.
module resolver_signal_emulator #(
	parameter int PHASE_BITS = rse_pkg::PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = rse_pkg::SINE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS = rse_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rse_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                excitation,
	output logic signed [15:0]                sin_secondary,
	output logic signed [15:0]                cos_secondary,
	output logic [15:0]                       rotor_angle
);

	rse_pkg::cfg_t cfg;
	rse_pkg::cmd_t cmd;

	rse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rse_dp #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.restart       (restart),
		.excitation    (excitation),
		.sin_secondary (sin_secondary),
		.cos_secondary (cos_secondary),
		.rotor_angle   (rotor_angle)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared straight from idle");

	a_exc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (SAMPLE_BITS == 16) |-> excitation != 16'sh8000)
		else $error("excitation beyond table range");

endmodule

// ===== tb/resolver_signal_emulator_check.sv =====
`timescale 1ns / 1ps
// Checker of the resolver signal emulator: follows register writes, predicts every tick
// from its own sine table and accumulators and compares each result as it is taken.
// Depends on rse_pkg for the register indexes and the configuration layout.
module resolver_signal_emulator_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rse_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	input  logic                              pready,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [15:0]                excitation,
	input  logic signed [15:0]                sin_secondary,
	input  logic signed [15:0]                cos_secondary,
	input  logic [15:0]                       rotor_angle,
	output int                                mismatches,
	output int                                outstanding
);

	typedef struct packed {
		logic signed [15:0] excitation;
		logic signed [15:0] sin_sec;
		logic signed [15:0] cos_sec;
		logic [15:0]        angle;
	} samples_t;

	localparam logic [63:0] Q30 = 64'd1 << 30;
	localparam logic [63:0] HALF_PI = 64'd1686629713;

	logic signed [15:0] sine_lut [0:1023];
	samples_t expected_samples [$];
	rse_pkg::cfg_t cfg;
	logic [31:0] carrier_acc;
	logic [31:0] angle_acc;
	int fail_count;

	function automatic logic [15:0] quadrant_sine(input logic [63:0] q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] div;
		int n;
		x = (HALF_PI * q) >> 8;
		x2 = (x * x) >> 30;
		t = Q30;
		for (n = 12; n >= 2; n -= 2) begin
			div = 64'(n * (n + 1));
			t = Q30 - ((x2 * t) >> 30) / div;
		end
		s = (x * t) >> 30;
		v = (s * 64'd32767 + (Q30 >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] winding(input logic [14:0] gain,
			input logic signed [15:0] car, input logic signed [15:0] rot,
			input logic signed [15:0] ofs);
		logic signed [31:0] prod;
		logic [31:0] mag;
		logic [63:0] rnd;
		logic signed [31:0] v;
		logic neg;
		prod = car * rot;
		neg = prod[31];
		mag = neg ? -prod : prod;
		rnd = ({32'd0, mag} * {49'd0, gain} + (64'd1 << 29)) >> 30;
		v = neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
		v = v + ofs;
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return v[15:0];
	endfunction

	initial begin : fill_lut
		int k;
		logic [7:0] r;
		logic [15:0] mag;
		for (k = 0; k < 1024; k++) begin
			r = k[7:0];
			mag = k[8] ? quadrant_sine(64'd256 - r) : quadrant_sine({56'd0, r});
			sine_lut[k] = k[9] ? -mag : mag;
		end
	end

	always @(posedge clk or negedge arst_n) begin : track
		samples_t want;
		logic [31:0] ph;
		logic [9:0] ai;
		logic signed [15:0] sc;
		logic signed [15:0] cc;
		if (!arst_n) begin
			cfg.exc_step = 32'd10737418;
			cfg.rotor_step = 32'd13675187;
			cfg.sin_gain = 15'd26214;
			cfg.cos_gain = 15'd26214;
			cfg.sin_shift = '0;
			cfg.cos_shift = '0;
			cfg.sin_offset = '0;
			cfg.cos_offset = '0;
			carrier_acc = '0;
			angle_acc = '0;
			expected_samples.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (rse_pkg::reg_idx_t'(paddr[4:2]))
					rse_pkg::REG_EXC_STEP: cfg.exc_step = pwdata;
					rse_pkg::REG_ROTOR_STEP: cfg.rotor_step = pwdata;
					rse_pkg::REG_SIN_GAIN: cfg.sin_gain = pwdata[14:0];
					rse_pkg::REG_COS_GAIN: cfg.cos_gain = pwdata[14:0];
					rse_pkg::REG_SIN_SHIFT: cfg.sin_shift = pwdata;
					rse_pkg::REG_COS_SHIFT: cfg.cos_shift = pwdata;
					rse_pkg::REG_SIN_OFFSET: cfg.sin_offset = pwdata[15:0];
					rse_pkg::REG_COS_OFFSET: cfg.cos_offset = pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: exc %0d sin %0d cos %0d angle %0d",
							excitation, sin_secondary, cos_secondary, rotor_angle);
					end
				end else begin
					want = expected_samples.pop_front();
					if (want.excitation !== excitation || want.sin_sec !== sin_secondary ||
							want.cos_sec !== cos_secondary || want.angle !== rotor_angle) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("mismatch: expected exc %0d sin %0d cos %0d angle %0d, ",
								want.excitation, want.sin_sec, want.cos_sec, want.angle);
							$display("got exc %0d sin %0d cos %0d angle %0d",
								excitation, sin_secondary, cos_secondary, rotor_angle);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				if (restart) begin
					carrier_acc = '0;
					angle_acc = '0;
				end
				ph = carrier_acc + cfg.sin_shift;
				sc = sine_lut[ph[31:22]];
				ph = carrier_acc + cfg.cos_shift;
				cc = sine_lut[ph[31:22]];
				ai = angle_acc[31:22];
				want.excitation = sine_lut[carrier_acc[31:22]];
				want.sin_sec = winding(cfg.sin_gain, sc, sine_lut[ai], cfg.sin_offset);
				ai = ai + 10'd256;
				want.cos_sec = winding(cfg.cos_gain, cc, sine_lut[ai], cfg.cos_offset);
				want.angle = angle_acc[31:16];
				expected_samples.push_back(want);
				carrier_acc = carrier_acc + cfg.exc_step;
				angle_acc = angle_acc + cfg.rotor_step;
			end
		end
		mismatches <= fail_count;
		outstanding <= expected_samples.size();
	end

endmodule

// ===== tb/resolver_signal_emulator_test.sv =====
`timescale 1ns / 1ps
// Top of the resolver signal emulator testbench: clock, reset, register setups and tick
// requests with random gaps and output stalls; the checker beside the block gives the count.
// Depends on rse_pkg, resolver_signal_emulator and resolver_signal_emulator_check.
module resolver_signal_emulator_test;

	localparam int LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [rse_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] excitation;
	logic signed [15:0] sin_secondary;
	logic signed [15:0] cos_secondary;
	logic [15:0] rotor_angle;
	int mismatches;
	int outstanding;
	int cycles = 0;

	always #6 clk = ~clk;

	resolver_signal_emulator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.excitation(excitation),
		.sin_secondary(sin_secondary),
		.cos_secondary(cos_secondary),
		.rotor_angle(rotor_angle)
	);

	resolver_signal_emulator_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.excitation(excitation),
		.sin_secondary(sin_secondary),
		.cos_secondary(cos_secondary),
		.rotor_angle(rotor_angle),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] field_value(input logic [31:0] mask);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return mask;
			2: return mask >> 1;
			3: return (mask >> 1) + 32'd1;
			4: return $urandom & (mask >> $urandom_range(1, 20));
			default: return $urandom & mask;
		endcase
	endfunction

	task automatic write_reg(input rse_pkg::reg_idx_t r, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
	endtask

	task automatic apply_cfg(input rse_pkg::cfg_t c);
		write_reg(rse_pkg::REG_EXC_STEP, c.exc_step);
		write_reg(rse_pkg::REG_ROTOR_STEP, c.rotor_step);
		write_reg(rse_pkg::REG_SIN_GAIN, {17'd0, c.sin_gain});
		write_reg(rse_pkg::REG_COS_GAIN, {17'd0, c.cos_gain});
		write_reg(rse_pkg::REG_SIN_SHIFT, c.sin_shift);
		write_reg(rse_pkg::REG_COS_SHIFT, c.cos_shift);
		write_reg(rse_pkg::REG_SIN_OFFSET, {{16{c.sin_offset[15]}}, c.sin_offset});
		write_reg(rse_pkg::REG_COS_OFFSET, {{16{c.cos_offset[15]}}, c.cos_offset});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_tick(input logic rs);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (12) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The receiver holds off twice for a long stretch so that the block backs up.
	initial begin : sink
		int n;
		int taken;
		int holds;
		logic rdy;
		taken = 0;
		holds = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds < 2 && taken >= 400 * (holds + 1)) begin
				rdy = 1'b0;
				n = 300;
				holds++;
			end else begin
				rdy = $urandom_range(0, 9) < 7;
				n = idle_len() + 1;
			end
			out_ready <= rdy;
			repeat (n) begin
				@(posedge clk);
				if (out_valid && out_ready) begin
					taken++;
				end
			end
		end
	end

	initial begin : stimulus
		rse_pkg::cfg_t c;
		int p;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();

		// Full-scale steps wrap both accumulators backwards; offsets drive saturation.
		c.exc_step = '1;
		c.rotor_step = '1;
		c.sin_gain = '1;
		c.cos_gain = '1;
		c.sin_shift = '1;
		c.cos_shift = '1;
		c.sin_offset = 16'sh7FFF;
		c.cos_offset = 16'sh8000;
		apply_cfg(c);
		send_tick(1'b1);
		for (n = 0; n < 5; n++) begin
			send_tick(1'b0);
		end
		settle();

		c.exc_step = '0;
		c.rotor_step = '0;
		c.sin_gain = '0;
		c.cos_gain = '0;
		c.sin_shift = 32'h8000_0000;
		c.cos_shift = '0;
		c.sin_offset = 16'sh8000;
		c.cos_offset = 16'sh7FFF;
		apply_cfg(c);
		send_tick(1'b1);
		for (n = 0; n < 3; n++) begin
			send_tick(1'b0);
		end
		settle();

		// Quarter-turn steps land on the sine peaks and zeros, so the cos products reach full scale.
		c.exc_step = 32'h4000_0000;
		c.rotor_step = 32'h4000_0000;
		c.sin_gain = '1;
		c.cos_gain = '1;
		c.sin_shift = 32'h4000_0000;
		c.cos_shift = 32'hC000_0000;
		c.sin_offset = '0;
		c.cos_offset = '0;
		apply_cfg(c);
		send_tick(1'b1);
		for (n = 0; n < 6; n++) begin
			send_tick(1'b0);
		end
		settle();

		for (p = 0; p < 6; p++) begin
			c.exc_step = field_value(32'hFFFF_FFFF);
			c.rotor_step = field_value(32'hFFFF_FFFF);
			c.sin_gain = 15'(field_value(32'h7FFF));
			c.cos_gain = 15'(field_value(32'h7FFF));
			c.sin_shift = field_value(32'hFFFF_FFFF);
			c.cos_shift = field_value(32'hFFFF_FFFF);
			c.sin_offset = 16'(field_value(32'hFFFF));
			c.cos_offset = 16'(field_value(32'hFFFF));
			apply_cfg(c);
			for (n = 0; n < 242; n++) begin
				send_tick($urandom_range(0, 15) == 0);
			end
			settle();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
